// File: sv/edsp_pkg.sv
package edsp_pkg;

  localparam int IDLE_COUNT_WIDTH = 12;
  localparam int LIMIT_W          = 12;
  localparam int CMP_W            = (IDLE_COUNT_WIDTH > LIMIT_W) ? IDLE_COUNT_WIDTH : LIMIT_W;
  localparam int DUTY_W           = 7;
  localparam int STEP_W           = 4;
  localparam int SUM_W            = DUTY_W + 2;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 12;

  localparam logic [CFG_IDX_W-1:0] REG_DUTY_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT = 2'd3;

  localparam logic [STEP_W-1:0]  RST_DUTY_STEP  = 4'd1;
  localparam logic [DUTY_W-1:0]  RST_DUTY_MIN   = 7'd25;
  localparam logic [DUTY_W-1:0]  RST_DUTY_MAX   = 7'd80;
  localparam logic [LIMIT_W-1:0] RST_IDLE_LIMIT = 12'd2000;
  localparam logic [DUTY_W-1:0]  RST_DUTY       = 7'd25;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;

  localparam logic [1:0] PINS_00 = 2'b00;
  localparam logic [1:0] PINS_01 = 2'b01;
  localparam logic [1:0] PINS_10 = 2'b10;
  localparam logic [1:0] PINS_11 = 2'b11;

  typedef struct packed {
    logic [STEP_W-1:0]  duty_step;
    logic [DUTY_W-1:0]  duty_min;
    logic [DUTY_W-1:0]  duty_max;
    logic [LIMIT_W-1:0] idle_limit_ms;
  } edsp_cfg_t;

  typedef struct packed {
    logic [1:0]                  prev_pins;
    logic [DUTY_W-1:0]           duty;
    logic [IDLE_COUNT_WIDTH-1:0] idle_cnt;
    logic                        auto_flag;
  } edsp_state_t;

endpackage

// File: sv/edsp_in_if.sv
interface edsp_in_if;
  logic valid;
  logic ready;
  logic pin_a;
  logic pin_b;
  logic ms_tick;

  modport source (output valid, output pin_a, output pin_b, output ms_tick, input ready);
  modport sink   (input valid, input pin_a, input pin_b, input ms_tick, output ready);
endinterface

// File: sv/edsp_out_if.sv
interface edsp_out_if;
  logic                        valid;
  logic                        ready;
  logic [edsp_pkg::DUTY_W-1:0] duty_setpoint;
  logic                        auto_mode;
  logic [1:0]                  step_dir;

  modport source (output valid, output duty_setpoint, output auto_mode, output step_dir,
                  input ready);
  modport sink   (input valid, input duty_setpoint, input auto_mode, input step_dir,
                  output ready);
endinterface

// File: sv/edsp_update.sv
module edsp_update (
  input  edsp_pkg::edsp_state_t state,
  input  edsp_pkg::edsp_cfg_t   cfg,
  input  logic [1:0]            pins,
  input  logic                  ms_tick,
  output edsp_pkg::edsp_state_t state_nxt,
  output logic [1:0]            dir
);

  logic signed [edsp_pkg::SUM_W-1:0] sum;
  logic signed [edsp_pkg::SUM_W-1:0] lo_clamped;
  logic signed [edsp_pkg::SUM_W-1:0] min_s;
  logic signed [edsp_pkg::SUM_W-1:0] max_s;
  logic signed [edsp_pkg::SUM_W-1:0] duty_s;
  logic signed [edsp_pkg::SUM_W-1:0] step_s;
  logic [edsp_pkg::IDLE_COUNT_WIDTH-1:0] cnt_inc;

  always_comb begin
    dir = edsp_pkg::DIR_NONE;
    case ({state.prev_pins, pins})
      {edsp_pkg::PINS_01, edsp_pkg::PINS_11},
      {edsp_pkg::PINS_11, edsp_pkg::PINS_10},
      {edsp_pkg::PINS_10, edsp_pkg::PINS_00},
      {edsp_pkg::PINS_00, edsp_pkg::PINS_01}: dir = edsp_pkg::DIR_CW;
      {edsp_pkg::PINS_00, edsp_pkg::PINS_10},
      {edsp_pkg::PINS_10, edsp_pkg::PINS_11},
      {edsp_pkg::PINS_11, edsp_pkg::PINS_01},
      {edsp_pkg::PINS_01, edsp_pkg::PINS_00}: dir = edsp_pkg::DIR_CCW;
      default: dir = edsp_pkg::DIR_NONE;
    endcase
  end

  assign duty_s = $signed(edsp_pkg::SUM_W'(state.duty));
  assign step_s = $signed(edsp_pkg::SUM_W'(cfg.duty_step));
  assign min_s  = $signed(edsp_pkg::SUM_W'(cfg.duty_min));
  assign max_s  = $signed(edsp_pkg::SUM_W'(cfg.duty_max));

  always_comb begin
    sum        = (dir == edsp_pkg::DIR_CW) ? duty_s + step_s : duty_s - step_s;
    lo_clamped = (sum < min_s) ? min_s : sum;
    cnt_inc    = state.idle_cnt;
    if (ms_tick && (state.idle_cnt != {edsp_pkg::IDLE_COUNT_WIDTH{1'b1}})) begin
      cnt_inc = state.idle_cnt + 1'b1;
    end

    state_nxt           = state;
    state_nxt.prev_pins = pins;
    if (dir != edsp_pkg::DIR_NONE) begin
      state_nxt.duty = (lo_clamped > max_s) ? cfg.duty_max
                                            : lo_clamped[edsp_pkg::DUTY_W-1:0];
    end
    if (pins != state.prev_pins) begin
      state_nxt.idle_cnt  = '0;
      state_nxt.auto_flag = 1'b0;
    end else begin
      state_nxt.idle_cnt  = cnt_inc;
      state_nxt.auto_flag = state.auto_flag |
        (edsp_pkg::CMP_W'(cnt_inc) > edsp_pkg::CMP_W'(cfg.idle_limit_ms));
    end
  end

endmodule

// File: sv/encoder_duty_setpoint_with_idle_mode_core.sv
// channel  dir  payload                               handshake
// in_ch    in   pin_a, pin_b, ms_tick                 valid/ready
// out_ch   out  duty_setpoint, auto_mode, step_dir    valid/ready
// cfg      in   cfg_we, cfg_idx, cfg_wdata            write strobe, no wait
//
// One word per cycle unless out_ch stalls; decode and clamp feed the single
// result register, whose output appears in the cycle after the word is taken.
// Input is taken whenever the result register is empty or being emptied.
// Synchronous active-low reset clears state, registers and output valid.
module encoder_duty_setpoint_with_idle_mode_core (
  input  logic                                clk,
  input  logic                                rst_n,
  edsp_in_if.sink                             in_ch,
  edsp_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [edsp_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [edsp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  edsp_pkg::edsp_cfg_t   cfg_r;
  edsp_pkg::edsp_state_t state_r;
  edsp_pkg::edsp_state_t state_nxt;
  logic [1:0]            dir;
  logic [1:0]            dir_r;
  logic                  out_valid_r;
  logic                  in_acc;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  edsp_update u_update (
    .state     (state_r),
    .cfg       (cfg_r),
    .pins      ({in_ch.pin_b, in_ch.pin_a}),
    .ms_tick   (in_ch.ms_tick),
    .state_nxt (state_nxt),
    .dir       (dir)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.duty_step     <= edsp_pkg::RST_DUTY_STEP;
      cfg_r.duty_min      <= edsp_pkg::RST_DUTY_MIN;
      cfg_r.duty_max      <= edsp_pkg::RST_DUTY_MAX;
      cfg_r.idle_limit_ms <= edsp_pkg::RST_IDLE_LIMIT;
    end else if (cfg_we) begin
      case (cfg_idx)
        edsp_pkg::REG_DUTY_STEP:  cfg_r.duty_step     <= cfg_wdata[edsp_pkg::STEP_W-1:0];
        edsp_pkg::REG_DUTY_MIN:   cfg_r.duty_min      <= cfg_wdata[edsp_pkg::DUTY_W-1:0];
        edsp_pkg::REG_DUTY_MAX:   cfg_r.duty_max      <= cfg_wdata[edsp_pkg::DUTY_W-1:0];
        edsp_pkg::REG_IDLE_LIMIT: cfg_r.idle_limit_ms <= cfg_wdata[edsp_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.prev_pins <= '0;
      state_r.duty      <= edsp_pkg::RST_DUTY;
      state_r.idle_cnt  <= '0;
      state_r.auto_flag <= 1'b0;
      out_valid_r       <= 1'b0;
      dir_r             <= edsp_pkg::DIR_NONE;
    end else begin
      if (in_acc) begin
        state_r     <= state_nxt;
        dir_r       <= dir;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.duty_setpoint = state_r.duty;
  assign out_ch.auto_mode     = state_r.auto_flag;
  assign out_ch.step_dir      = dir_r;

`ifndef SYNTHESIS
  a_dir_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (dir_r != 2'd3))
    else $error("step direction code out of range");

  a_auto_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.auto_flag |-> (state_r.idle_cnt != '0))
    else $error("automatic mode with cleared idle counter");

  a_change_manual: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && ({in_ch.pin_b, in_ch.pin_a} != state_r.prev_pins))
      |=> (!state_r.auto_flag && (state_r.idle_cnt == '0)))
    else $error("pin change did not select manual mode");
`endif

endmodule

// File: verif/edsp_setpoint_checker.sv
`timescale 1ns / 100ps

module edsp_setpoint_checker
  import edsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  edsp_in_if                    in_ch,
  edsp_out_if                   out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    n_errors,
  output int                    n_pending
);

  typedef struct packed {
    logic [DUTY_W-1:0] duty_setpoint;
    logic              auto_mode;
    logic [1:0]        step_dir;
  } setpoint_word_t;

  edsp_cfg_t      cfg_shadow;
  edsp_state_t    enc;
  setpoint_word_t setpoint_q[$];

  function automatic logic [1:0] decode_dir(input logic [1:0] from, input logic [1:0] to);
    case ({from, to})
      {PINS_01, PINS_11}, {PINS_11, PINS_10},
      {PINS_10, PINS_00}, {PINS_00, PINS_01}: return DIR_CW;
      {PINS_00, PINS_10}, {PINS_10, PINS_11},
      {PINS_11, PINS_01}, {PINS_01, PINS_00}: return DIR_CCW;
      default: return DIR_NONE;
    endcase
  endfunction

  task automatic predict_setpoint(input logic [1:0] pins, input logic tick);
    logic [1:0]     dir;
    int             d;
    setpoint_word_t w;
    dir = decode_dir(enc.prev_pins, pins);
    if (dir != DIR_NONE) begin
      // clamp on the full signed value, high limit last
      d = int'(enc.duty);
      if (dir == DIR_CW) d += int'(cfg_shadow.duty_step);
      else d -= int'(cfg_shadow.duty_step);
      if (d < int'(cfg_shadow.duty_min)) d = int'(cfg_shadow.duty_min);
      if (d > int'(cfg_shadow.duty_max)) d = int'(cfg_shadow.duty_max);
      enc.duty = d[DUTY_W-1:0];
    end
    if (pins != enc.prev_pins) begin
      enc.idle_cnt  = '0;
      enc.auto_flag = 1'b0;
    end else begin
      if (tick && enc.idle_cnt != '1) enc.idle_cnt = enc.idle_cnt + 1'b1;
      if (enc.idle_cnt > cfg_shadow.idle_limit_ms) enc.auto_flag = 1'b1;
    end
    enc.prev_pins = pins;
    w.duty_setpoint = enc.duty;
    w.auto_mode     = enc.auto_flag;
    w.step_dir      = dir;
    setpoint_q.push_back(w);
  endtask

  always @(posedge clk) begin : watch
    setpoint_word_t got;
    setpoint_word_t want;
    if (!rst_n) begin
      cfg_shadow = '{RST_DUTY_STEP, RST_DUTY_MIN, RST_DUTY_MAX, RST_IDLE_LIMIT};
      enc        = '{PINS_00, RST_DUTY, '0, 1'b0};
      setpoint_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.duty_setpoint, out_ch.auto_mode, out_ch.step_dir};
        if (setpoint_q.size() == 0) begin
          n_errors++;
          $error("result word with none expected: duty_setpoint %0d auto_mode %0d step_dir %0d",
                 got.duty_setpoint, got.auto_mode, got.step_dir);
        end else begin
          want = setpoint_q.pop_front();
          if (got.duty_setpoint !== want.duty_setpoint) begin
            n_errors++;
            $error("duty_setpoint: expected %0d, got %0d", want.duty_setpoint, got.duty_setpoint);
          end
          if (got.auto_mode !== want.auto_mode) begin
            n_errors++;
            $error("auto_mode: expected %0d, got %0d", want.auto_mode, got.auto_mode);
          end
          if (got.step_dir !== want.step_dir) begin
            n_errors++;
            $error("step_dir: expected %0d, got %0d", want.step_dir, got.step_dir);
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        predict_setpoint({in_ch.pin_b, in_ch.pin_a}, in_ch.ms_tick);
      if (cfg_we) begin
        case (cfg_idx)
          REG_DUTY_STEP:  cfg_shadow.duty_step     = cfg_wdata[STEP_W-1:0];
          REG_DUTY_MIN:   cfg_shadow.duty_min      = cfg_wdata[DUTY_W-1:0];
          REG_DUTY_MAX:   cfg_shadow.duty_max      = cfg_wdata[DUTY_W-1:0];
          REG_IDLE_LIMIT: cfg_shadow.idle_limit_ms = cfg_wdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
    n_pending <= setpoint_q.size();
  end

endmodule

// File: verif/encoder_duty_setpoint_with_idle_mode_core_tb.sv
`timescale 1ns / 100ps

module encoder_duty_setpoint_with_idle_mode_core_tb;
  import edsp_pkg::*;

  localparam int HOLD_CYCLES = 120;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 48;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  hold_req;
  int                    n_errors;
  int                    n_pending;
  int                    tx_idle_pct;
  int                    rx_idle_pct;
  int                    cyc;
  logic [1:0]            pins_now;

  // {ms_tick, pin_b, pin_a}
  logic [2:0] directed_seq [22] = '{
    3'b100, 3'b101, 3'b011, 3'b110, 3'b000, 3'b001, 3'b100, 3'b010,
    3'b011, 3'b101, 3'b000, 3'b010, 3'b101, 3'b010, 3'b000, 3'b111,
    3'b111, 3'b111, 3'b011, 3'b111, 3'b101, 3'b101
  };

  edsp_in_if  in_ch ();
  edsp_out_if out_ch ();

  encoder_duty_setpoint_with_idle_mode_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  edsp_setpoint_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .n_errors  (n_errors),
    .n_pending (n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int held;
    held = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && held < HOLD_CYCLES) begin
        out_ch.ready <= 1'b0;
        held++;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic [1:0] cw_next(input logic [1:0] p);
    case (p)
      PINS_01: return PINS_11;
      PINS_11: return PINS_10;
      PINS_10: return PINS_00;
      default: return PINS_01;
    endcase
  endfunction

  function automatic logic [1:0] ccw_next(input logic [1:0] p);
    case (p)
      PINS_01: return PINS_00;
      PINS_00: return PINS_10;
      PINS_10: return PINS_11;
      default: return PINS_01;
    endcase
  endfunction

  task automatic send_word(input logic [1:0] pins, input logic tick);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.pin_a   <= pins[0];
    in_ch.pin_b   <= pins[1];
    in_ch.ms_tick <= tick;
    do @(posedge clk); while (!in_ch.ready);
    pins_now = pins;
  endtask

  // stop offering and wait until every predicted word has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // junk above each register's width must be masked off
  task automatic configure(input logic [STEP_W-1:0] st, input logic [DUTY_W-1:0] lo,
                           input logic [DUTY_W-1:0] hi, input logic [LIMIT_W-1:0] lim);
    cfg_put(REG_DUTY_STEP, CFG_DATA_W'(($urandom() << STEP_W) | st));
    cfg_put(REG_DUTY_MIN,  CFG_DATA_W'(($urandom() << DUTY_W) | lo));
    cfg_put(REG_DUTY_MAX,  CFG_DATA_W'(($urandom() << DUTY_W) | hi));
    cfg_put(REG_IDLE_LIMIT, lim);
    cfg_we <= 1'b0;
  endtask

  task automatic pick_setting(input int p);
    case (p)
      0: configure(4'd15, 7'd0, 7'd127, 12'd0);
      1: configure(4'd1, 7'd127, 7'd127, 12'd4095);
      2: configure(4'd7, 7'd100, 7'd20, 12'd5);
      4: configure(4'd15, 7'd120, 7'd127, 12'd2);
      5: configure(4'd1, 7'd0, 7'd0, 12'd1);
      6: configure(4'd8, 7'd0, 7'd10, 12'd10);
      8: configure(4'd3, 7'd60, 7'd70, 12'd7);
      9: configure(4'd12, 7'd5, 7'd127, 12'd0);
      default: configure(STEP_W'($urandom_range(1, 15)), DUTY_W'($urandom_range(127)),
                         DUTY_W'($urandom_range(127)), LIMIT_W'($urandom_range(20)));
    endcase
  endtask

  // runs of rotation, still spells with ticks, and the odd random word
  task automatic run_phase(input int n);
    int   sent;
    int   kind;
    int   len;
    logic cw;
    sent = 0;
    cw   = 1'b1;
    while (sent < n) begin
      kind = $urandom_range(9);
      if (kind < 5) begin
        len = $urandom_range(1, 8);
        if ($urandom_range(3) == 0) cw = !cw;
        repeat (len) send_word(cw ? cw_next(pins_now) : ccw_next(pins_now), 1'($urandom_range(1)));
      end else if (kind < 8) begin
        len = $urandom_range(1, 24);
        repeat (len) send_word(pins_now, $urandom_range(9) != 0);
      end else begin
        len = $urandom_range(1, 3);
        repeat (len) send_word(2'($urandom()), 1'($urandom_range(1)));
      end
      sent += len;
    end
  endtask

  initial begin : stimulus
    in_ch.valid   <= 1'b0;
    in_ch.pin_a   <= 1'b0;
    in_ch.pin_b   <= 1'b0;
    in_ch.ms_tick <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= '0;
    cfg_wdata     <= '0;
    hold_req      <= 1'b0;
    rst_n         <= 1'b0;
    pins_now    = PINS_00;
    tx_idle_pct = 23;
    rx_idle_pct = 83;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_seq[i]) send_word(directed_seq[i][1:0], directed_seq[i][2]);

    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 23 : (mode == 1) ? 83 : 0;
      rx_idle_pct = (mode == 0) ? 83 : (mode == 1) ? 23 : 0;
      for (int k = 0; k < 4; k++) begin
        settle();
        pick_setting(mode * 4 + k);
        if (mode == 0 && k == 1) hold_req <= 1'b1;
        run_phase(PHASE_WORDS);
      end
    end
    settle();

    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: encoder_duty_setpoint_with_idle_mode_core.f
sv/edsp_pkg.sv
sv/edsp_in_if.sv
sv/edsp_out_if.sv
sv/edsp_update.sv
sv/encoder_duty_setpoint_with_idle_mode_core.sv
verif/edsp_setpoint_checker.sv
verif/encoder_duty_setpoint_with_idle_mode_core_tb.sv
